// ===== rtl/core/yuv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// YUYV to RGB package
// Shared constants, types and the channel saturation function of the
// 4:2:2 to RGB888 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package yuv2rgb_pkg;

    // Fixed-point format and chroma offset.
    localparam int FRAC_BITS     = 10;
    localparam int CHROMA_OFFSET = 127;

    // Q10 colour-space coefficients.
    localparam int COEF_RV = 1436;
    localparam int COEF_GU = 352;
    localparam int COEF_GV = 731;
    localparam int COEF_BU = 1927;

    // Width of one chroma term and of one full channel sum.
    localparam int TERM_W = 19;
    localparam int SUM_W  = 20;

    // Chroma contributions shared by both pixels of a pair.
    typedef struct packed {
        logic signed [TERM_W-1:0] red;
        logic signed [TERM_W-1:0] green;
        logic signed [TERM_W-1:0] blue;
    } t_chroma;

    // One RGB888 pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Floor-shift a Q10 sum and clamp the result to 0..255.
    function automatic logic [7:0] saturate(input logic signed [SUM_W-1:0] sum);
        logic [7:0] result;
        if (sum[SUM_W-1]) begin
            result = 8'd0;
        end else if (sum[SUM_W-2]) begin
            result = 8'hFF;
        end else begin
            result = sum[FRAC_BITS+7:FRAC_BITS];
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/yuv2rgb_chroma.sv =====
// ----------------------------------------------------------------------------
// YUYV to RGB chroma terms
// Removes the chroma offset and forms the three Q10 chroma products that
// both pixel lanes share.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv2rgb_chroma (
    input  wire logic [7:0]           i_chroma_blue,
    input  wire logic [7:0]           i_chroma_red,
    output yuv2rgb_pkg::t_chroma      o_terms
);

    logic signed [8:0]                       w_du;
    logic signed [8:0]                       w_dv;
    logic signed [yuv2rgb_pkg::TERM_W-1:0]   w_du_ext;
    logic signed [yuv2rgb_pkg::TERM_W-1:0]   w_dv_ext;

    // Offset-free chroma differences, range -127 to 128.
    assign w_du = $signed({1'b0, i_chroma_blue}) - 9'(yuv2rgb_pkg::CHROMA_OFFSET);
    assign w_dv = $signed({1'b0, i_chroma_red}) - 9'(yuv2rgb_pkg::CHROMA_OFFSET);

    assign w_du_ext = yuv2rgb_pkg::TERM_W'(w_du);
    assign w_dv_ext = yuv2rgb_pkg::TERM_W'(w_dv);

    // Constant-coefficient products; the green term combines both differences.
    assign o_terms.red   = w_dv_ext
                           * yuv2rgb_pkg::TERM_W'(signed'(yuv2rgb_pkg::COEF_RV));
    assign o_terms.green = -(w_du_ext
                           * yuv2rgb_pkg::TERM_W'(signed'(yuv2rgb_pkg::COEF_GU)))
                           - (w_dv_ext
                           * yuv2rgb_pkg::TERM_W'(signed'(yuv2rgb_pkg::COEF_GV)));
    assign o_terms.blue  = w_du_ext
                           * yuv2rgb_pkg::TERM_W'(signed'(yuv2rgb_pkg::COEF_BU));

endmodule

`default_nettype wire

// ===== rtl/core/yuv2rgb_lane.sv =====
// ----------------------------------------------------------------------------
// YUYV to RGB pixel lane
// Adds the scaled luma of one pixel to the shared chroma terms and
// saturates each channel.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv2rgb_lane (
    input  wire logic [7:0]            i_luma,
    input  wire yuv2rgb_pkg::t_chroma  i_terms,
    output yuv2rgb_pkg::t_rgb          o_pixel
);

    logic signed [yuv2rgb_pkg::SUM_W-1:0] w_base;
    logic signed [yuv2rgb_pkg::SUM_W-1:0] w_sum_red;
    logic signed [yuv2rgb_pkg::SUM_W-1:0] w_sum_green;
    logic signed [yuv2rgb_pkg::SUM_W-1:0] w_sum_blue;

    // Luma in Q10, never negative.
    assign w_base = $signed({2'b00, i_luma, 10'b0});

    // Per-channel Q10 sums.
    assign w_sum_red   = w_base + yuv2rgb_pkg::SUM_W'(i_terms.red);
    assign w_sum_green = w_base + yuv2rgb_pkg::SUM_W'(i_terms.green);
    assign w_sum_blue  = w_base + yuv2rgb_pkg::SUM_W'(i_terms.blue);

    // Clamp to the 8-bit range.
    assign o_pixel.red   = yuv2rgb_pkg::saturate(w_sum_red);
    assign o_pixel.green = yuv2rgb_pkg::saturate(w_sum_green);
    assign o_pixel.blue  = yuv2rgb_pkg::saturate(w_sum_blue);

endmodule

`default_nettype wire

// ===== rtl/core/yuv2rgb_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// YUYV to RGB converter file index
// Holds no logic; the top level lives in yuyv_to_rgb_converter.sv.
// ----------------------------------------------------------------------------
`default_nettype none

`default_nettype wire

// ===== rtl/core/yuyv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// YUYV 4:2:2 to RGB888 converter
// Converts one packed pixel pair (Y0, U, Y1, V) into two RGB888 pixels.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one pixel pair per transaction, with a
//   frame-end flag that is passed through untouched. The output channel
//   returns exactly one transaction per input, holding both RGB pixels.
//   Both channels use valid and stall; a transaction completes on a clock
//   edge where valid is high and stall is low.
// Pipeline and throughput:
//   Each input is taken into a register stage after the chroma products,
//   and its result into an output register after the two pixel lanes. One
//   pixel pair is accepted every cycle while the output is not stalled,
//   so the sustained rate is one pair per clock.
// Reset:
//   A synchronous, active-low reset empties both stages; no data is kept.
// Stall:
//   When the receiver stalls, the output holds its result. The pipeline
//   keeps taking new pairs until both stages are full, after which the
//   input stall is raised in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module yuyv_to_rgb_converter (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Input channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_luma_first,
    input  wire logic [7:0] i_chroma_blue,
    input  wire logic [7:0] i_luma_second,
    input  wire logic [7:0] i_chroma_red,
    input  wire logic       i_frame_end_in,
    // Output channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_red_first,
    output logic [7:0]      o_green_first,
    output logic [7:0]      o_blue_first,
    output logic [7:0]      o_red_second,
    output logic [7:0]      o_green_second,
    output logic [7:0]      o_blue_second,
    output logic            o_frame_end_out
);

    yuv2rgb_pkg::t_chroma w_terms;
    yuv2rgb_pkg::t_rgb    w_pixel_first;
    yuv2rgb_pkg::t_rgb    w_pixel_second;

    // Stage one registers
    logic                 r_mid_valid;
    yuv2rgb_pkg::t_chroma r_terms;
    logic [7:0]           r_luma_first;
    logic [7:0]           r_luma_second;
    logic                 r_mid_frame_end;

    // Output registers
    logic                 r_out_valid;
    yuv2rgb_pkg::t_rgb    r_pixel_first;
    yuv2rgb_pkg::t_rgb    r_pixel_second;
    logic                 r_out_frame_end;

    logic                 w_out_load;
    logic                 w_mid_load;

    // Stage advance: a stage loads when it is empty or its content moves on.
    assign w_out_load = !r_out_valid || !i_stall;
    assign w_mid_load = !r_mid_valid || w_out_load;
    assign o_stall    = !w_mid_load;

    // Shared chroma products.
    yuv2rgb_chroma u_chroma (
        .i_chroma_blue (i_chroma_blue),
        .i_chroma_red  (i_chroma_red),
        .o_terms       (w_terms)
    );

    // Stage one valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (w_mid_load) begin
            r_mid_valid <= i_valid;
        end
    end

    // Stage one payload.
    always_ff @(posedge i_clk) begin
        if (w_mid_load && i_valid) begin
            r_terms         <= w_terms;
            r_luma_first    <= i_luma_first;
            r_luma_second   <= i_luma_second;
            r_mid_frame_end <= i_frame_end_in;
        end
    end

    // One lane per pixel of the pair.
    yuv2rgb_lane u_lane_first (
        .i_luma  (r_luma_first),
        .i_terms (r_terms),
        .o_pixel (w_pixel_first)
    );

    yuv2rgb_lane u_lane_second (
        .i_luma  (r_luma_second),
        .i_terms (r_terms),
        .o_pixel (w_pixel_second)
    );

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_mid_valid;
        end
    end

    // Merge both lanes and the frame-end flag into the output register.
    always_ff @(posedge i_clk) begin
        if (w_out_load && r_mid_valid) begin
            r_pixel_first   <= w_pixel_first;
            r_pixel_second  <= w_pixel_second;
            r_out_frame_end <= r_mid_frame_end;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_red_first     = r_pixel_first.red;
    assign o_green_first   = r_pixel_first.green;
    assign o_blue_first    = r_pixel_first.blue;
    assign o_red_second    = r_pixel_second.red;
    assign o_green_second  = r_pixel_second.green;
    assign o_blue_second   = r_pixel_second.blue;
    assign o_frame_end_out = r_out_frame_end;

endmodule

`default_nettype wire

// ===== sim/yuyv_to_rgb_converter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// YUYV 4:2:2 to RGB888 converter testbench
// Feeds pixel pairs through the converter with random idle bursts on both
// channels and long receiver hold-offs. It predicts every result with its
// own Q10 colour conversion and checks each output transaction field by field.
// ----------------------------------------------------------------------------

module yuyv_to_rgb_converter_tb;

    // Q10 conversion constants, kept independent of the design package.
    localparam int Q10_SHIFT     = 10;
    localparam int CHROMA_MID    = 127;
    localparam int Q10_RED_V     = 1436;
    localparam int Q10_GREEN_U   = 352;
    localparam int Q10_GREEN_V   = 731;
    localparam int Q10_BLUE_U    = 1927;

    localparam int RANDOM_PAIRS  = 600;
    localparam int CALM_TAIL     = 80;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 200000;

    // One packed 4:2:2 input group.
    typedef struct {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       frame_end;
    } t_yuyv_pair;

    // Two RGB888 pixels and the frame-end flag.
    typedef struct {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       frame_end;
    } t_rgb_pair;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic       o_stall;
    logic [7:0] i_luma_first    = 8'd0;
    logic [7:0] i_chroma_blue   = 8'd0;
    logic [7:0] i_luma_second   = 8'd0;
    logic [7:0] i_chroma_red    = 8'd0;
    logic       i_frame_end_in  = 1'b0;
    logic       o_valid;
    logic       i_stall         = 1'b0;
    logic [7:0] o_red_first;
    logic [7:0] o_green_first;
    logic [7:0] o_blue_first;
    logic [7:0] o_red_second;
    logic [7:0] o_green_second;
    logic [7:0] o_blue_second;
    logic       o_frame_end_out;

    t_yuyv_pair pending_pairs[$];
    t_rgb_pair  expected_rgb[$];
    t_yuyv_pair offered_pair;

    int pairs_accepted  = 0;
    int total_pairs     = 0;
    int cycle_count     = 0;
    int mismatch_count  = 0;
    int results_seen    = 0;
    int tx_gap          = 0;
    int rx_burst        = 0;
    int hold_left       = 0;
    int next_hold_at    = 100;

    yuyv_to_rgb_converter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_luma_first    (i_luma_first),
        .i_chroma_blue   (i_chroma_blue),
        .i_luma_second   (i_luma_second),
        .i_chroma_red    (i_chroma_red),
        .i_frame_end_in  (i_frame_end_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_red_first     (o_red_first),
        .o_green_first   (o_green_first),
        .o_blue_first    (o_blue_first),
        .o_red_second    (o_red_second),
        .o_green_second  (o_green_second),
        .o_blue_second   (o_blue_second),
        .o_frame_end_out (o_frame_end_out)
    );

    // Clock with a 10 ns period.
    always #5 i_clk = ~i_clk;

    // Floor-shift a Q10 sum and clamp it to one 8-bit channel.
    function automatic logic [7:0] clamp_q10(input int sum);
        int shifted;
        if (sum < 0) begin
            return 8'd0;
        end
        shifted = sum >>> Q10_SHIFT;
        if (shifted > 255) begin
            return 8'd255;
        end
        return shifted[7:0];
    endfunction

    // Predict both RGB pixels of a pair; the chroma is shared.
    function automatic t_rgb_pair convert_pair(input t_yuyv_pair pair);
        int        du;
        int        dv;
        int        base_first;
        int        base_second;
        t_rgb_pair rgb;
        du          = int'(pair.chroma_blue) - CHROMA_MID;
        dv          = int'(pair.chroma_red) - CHROMA_MID;
        base_first  = int'(pair.luma_first) << Q10_SHIFT;
        base_second = int'(pair.luma_second) << Q10_SHIFT;
        rgb.red_first    = clamp_q10(base_first + Q10_RED_V * dv);
        rgb.green_first  = clamp_q10(base_first - Q10_GREEN_U * du - Q10_GREEN_V * dv);
        rgb.blue_first   = clamp_q10(base_first + Q10_BLUE_U * du);
        rgb.red_second   = clamp_q10(base_second + Q10_RED_V * dv);
        rgb.green_second = clamp_q10(base_second - Q10_GREEN_U * du - Q10_GREEN_V * dv);
        rgb.blue_second  = clamp_q10(base_second + Q10_BLUE_U * du);
        rgb.frame_end    = pair.frame_end;
        return rgb;
    endfunction

    // Idle bursts are allowed except in calm stretches and in the tail of the run.
    function automatic bit idling_allowed();
        return (pairs_accepted < total_pairs - CALM_TAIL) && ((cycle_count / 700) % 4 != 3);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch in result %0d: %s is %0d, expected %0d", results_seen, what, got,
                 want);
        mismatch_count++;
    endtask

    task automatic check_channel(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want) begin
            report_mismatch(what, int'(got), int'(want));
        end
    endtask

    task automatic add_pair(input logic [7:0] y0, input logic [7:0] u, input logic [7:0] y1,
                            input logic [7:0] v, input logic fe);
        t_yuyv_pair pair;
        pair.luma_first  = y0;
        pair.chroma_blue = u;
        pair.luma_second = y1;
        pair.chroma_red  = v;
        pair.frame_end   = fe;
        pending_pairs.push_back(pair);
    endtask

    // Cycle counter and run-time limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("yuyv_to_rgb_converter_tb NOT OK");
            $finish;
        end
    end

    // Driver: offers queued pairs, holds a stalled transaction, inserts idle bursts.
    always @(posedge i_clk) begin : driver
        logic offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            offer = i_valid;
            if (i_valid && !o_stall) begin
                expected_rgb.push_back(convert_pair(offered_pair));
                pairs_accepted <= pairs_accepted + 1;
                offer = 1'b0;
            end
            if (!offer) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_pairs.size() > 0) begin
                    if (idling_allowed() && $urandom_range(0, 7) == 0) begin
                        tx_gap = $urandom_range(1, 19) - 1;
                    end else begin
                        offered_pair    = pending_pairs.pop_front();
                        offer           = 1'b1;
                        i_luma_first   <= offered_pair.luma_first;
                        i_chroma_blue  <= offered_pair.chroma_blue;
                        i_luma_second  <= offered_pair.luma_second;
                        i_chroma_red   <= offered_pair.chroma_red;
                        i_frame_end_in <= offered_pair.frame_end;
                    end
                end
            end
            i_valid <= offer;
        end
    end

    // Long receiver hold-offs so that the pipeline fills and stalls its input.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (i_rst_n && pairs_accepted >= next_hold_at && next_hold_at <= 400) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 300;
        end
    end

    // Monitor: checks each output transaction and drives the output stall.
    always @(posedge i_clk) begin : monitor
        t_rgb_pair want;
        logic      next_stall;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_rgb.size() == 0) begin
                    report_mismatch("unexpected result, frame_end", int'(o_frame_end_out), 0);
                end else begin
                    want = expected_rgb.pop_front();
                    check_channel("red_first", o_red_first, want.red_first);
                    check_channel("green_first", o_green_first, want.green_first);
                    check_channel("blue_first", o_blue_first, want.blue_first);
                    check_channel("red_second", o_red_second, want.red_second);
                    check_channel("green_second", o_green_second, want.green_second);
                    check_channel("blue_second", o_blue_second, want.blue_second);
                    if (o_frame_end_out !== want.frame_end) begin
                        report_mismatch("frame_end_out", int'(o_frame_end_out),
                                        int'(want.frame_end));
                    end
                end
                results_seen++;
            end
            if (rx_burst > 0) begin
                rx_burst--;
                next_stall = 1'b1;
            end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
                rx_burst   = $urandom_range(1, 19) - 1;
                next_stall = 1'b1;
            end else begin
                next_stall = 1'b0;
            end
            i_stall <= next_stall || (hold_left > 0);
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int kind;
        // Directed pairs: extremes, saturation on both sides, neutral chroma.
        add_pair(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        add_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        add_pair(8'd0, 8'd127, 8'd255, 8'd127, 1'b0);
        add_pair(8'd128, 8'd127, 8'd1, 8'd127, 1'b1);
        add_pair(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
        add_pair(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
        add_pair(8'd200, 8'd255, 8'd40, 8'd127, 1'b0);
        add_pair(8'd20, 8'd0, 8'd230, 8'd127, 1'b0);
        add_pair(8'd200, 8'd127, 8'd40, 8'd255, 1'b0);
        add_pair(8'd20, 8'd127, 8'd230, 8'd0, 1'b1);
        add_pair(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0);
        add_pair(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b1);
        add_pair(8'd128, 8'd128, 8'd127, 8'd126, 1'b0);
        add_pair(8'd1, 8'd126, 8'd254, 8'd128, 1'b0);
        add_pair(8'd16, 8'd128, 8'd235, 8'd128, 1'b1);
        // Random pairs: mostly uniform, some with chroma near neutral.
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            kind = $urandom_range(0, 3);
            if (kind == 0) begin
                add_pair(8'($urandom_range(0, 255)), 8'($urandom_range(107, 147)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(107, 147)),
                         $urandom_range(0, 15) == 0);
            end else begin
                add_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         $urandom_range(0, 15) == 0);
            end
        end
        total_pairs = pending_pairs.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pairs_accepted < total_pairs || expected_rgb.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("yuyv_to_rgb_converter_tb OK");
        end else begin
            $display("yuyv_to_rgb_converter_tb NOT OK");
        end
        $finish;
    end

endmodule
